FILE: hw/rtl/scurve_trajectory_pid_axis_defines.svh
// Assertion macros shared by the S-curve axis RTL.
`ifndef SCURVE_TRAJECTORY_PID_AXIS_DEFINES_SVH
`define SCURVE_TRAJECTORY_PID_AXIS_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Check that cons holds in the same cycle as ante.
`define SCTP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sctp assertion failed");
// Check that cons holds in the cycle after ante.
`define SCTP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sctp assertion failed");
`else
`define SCTP_ASSERT_IMP(lbl, ante, cons)
`define SCTP_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: hw/rtl/sctp_pkg.sv
`timescale 1ns / 1ps
package sctp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int TPS       = 100;
  localparam int TBL_DEPTH = 256;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);
  localparam int TICK_W    = 20;
  localparam int DIV_W     = 50;
  localparam int PROD_W    = 67;
  localparam int SERIES_TERMS = 14;
  localparam logic [63:0] EXP_M1_Q32 = 64'd1580030169;

  typedef enum logic [2:0] {
    REG_PEAK  = 3'd0,
    REG_RAMP  = 3'd1,
    REG_CEND  = 3'd2,
    REG_TOTAL = 3'd3,
    REG_SLOPE = 3'd4,
    REG_KP    = 3'd5,
    REG_KI    = 3'd6,
    REG_KD    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [30:0]       peak;
    logic [TICK_W-1:0] ramp;
    logic [TICK_W-1:0] cend;
    logic [TICK_W-1:0] total;
    logic [30:0]       slope;
    logic [30:0]       kp;
    logic [30:0]       ki;
    logic [30:0]       kd;
  } cfg_t;

  typedef enum logic [2:0] {
    PH_OFF    = 3'd0,
    PH_RAMP   = 3'd1,
    PH_CRUISE = 3'd2,
    PH_DOWN   = 3'd3,
    PH_FINISH = 3'd4
  } phase_t;

  typedef enum logic [4:0] {
    OP_NONE    = 5'd0,
    OP_CAPTURE = 5'd1,
    OP_START   = 5'd2,
    OP_PHASE   = 5'd3,
    OP_MUL_P   = 5'd4,
    OP_LOOK    = 5'd5,
    OP_MUL_V   = 5'd6,
    OP_VSET    = 5'd7,
    OP_ACC     = 5'd8,
    OP_DIV_V   = 5'd9,
    OP_REFPOS  = 5'd10,
    OP_ERR     = 5'd11,
    OP_DIV_E   = 5'd12,
    OP_MUL_KP  = 5'd13,
    OP_MUL_KI  = 5'd14,
    OP_MUL_KD  = 5'd15,
    OP_SUM     = 5'd16,
    OP_DIV_C   = 5'd17,
    OP_OUT     = 5'd18
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic   action;
    phase_t phase;
    logic   active;
    logic   div_done;
    logic   out_free;
  } status_t;

  typedef logic [15:0] sig_rom_t [TBL_DEPTH];

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'sh7FFFFFFF;
    else if (x < -64'sd2147483648) return 32'sh80000000;
    else return x[31:0];
  endfunction

  // Unsigned quotient by shift and subtract, used only to build the table.
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], n[b]};
      if (rem >= {1'b0, d}) begin
        rem    = rem - {1'b0, d};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Build the logistic table: e^-x from a truncated series, then 1/(1+e^-x).
  function automatic sig_rom_t sig_rom_build();
    sig_rom_t    rom;
    longint      num;
    longint      sum;
    logic [63:0] mag, a, whole, frac, term, r, den, s;
    for (int i = 0; i < TBL_DEPTH; i++) begin
      num   = longint'(2 * i + 1 - TBL_DEPTH);
      mag   = (num < 0) ? 64'(-num) : 64'(num);
      a     = (mag << 35) >> TBL_AW;
      whole = a >> 32;
      frac  = {32'b0, a[31:0]};
      term  = 64'd1 << 32;
      sum   = longint'(1) << 32;
      for (int k = 1; k <= SERIES_TERMS; k++) begin
        term = udiv64((term * frac) >> 32, 64'(k));
        if (k[0]) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      r = (sum > 0) ? 64'(sum) : 64'd0;
      for (int k = 0; k < 8; k++) begin
        if (64'(k) < whole) r = (r * EXP_M1_Q32) >> 32;
      end
      den = (64'd1 << 32) + r;
      s   = (num >= 0) ? udiv64(64'd1 << 48, den) : udiv64(r << 16, den);
      rom[i] = (s > 64'd65535) ? 16'hFFFF : s[15:0];
    end
    return rom;
  endfunction

  localparam sig_rom_t SIG_ROM = sig_rom_build();

endpackage

FILE: hw/rtl/sctp_div.sv
`timescale 1ns / 1ps
module sctp_div
  import sctp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [DIV_W-1:0] dividend,
  output logic                    done,
  output logic signed [DIV_W-1:0] quotient
);

  localparam int CHUNK_W = DIV_W / 2;
  localparam int REM_W   = $clog2(TPS);
  localparam int PART_W  = REM_W + CHUNK_W;
  localparam int SHIFT   = PART_W + $clog2(TPS);
  localparam int MPROD_W = 2 * PART_W + 1;
  localparam logic [PART_W:0] RECIP =
    (PART_W + 1)'(((64'd1 << SHIFT) + 64'(TPS) - 64'd1) / 64'(TPS));

  logic                busy_r, done_r, step_r, neg_r;
  logic [DIV_W-1:0]    mag_r, quo_r;
  logic [REM_W-1:0]    rem_r;
  logic [CHUNK_W-1:0]  chunk, qd;
  logic [PART_W-1:0]   part, back;
  logic [MPROD_W-1:0]  prod;

  // One step: divide remainder and next chunk by a reciprocal multiply.
  always_comb begin
    chunk = step_r ? mag_r[CHUNK_W-1:0] : mag_r[DIV_W-1:CHUNK_W];
    part  = {rem_r, chunk};
    prod  = MPROD_W'(part) * MPROD_W'(RECIP);
    qd    = prod[SHIFT+CHUNK_W-1:SHIFT];
    back  = part - PART_W'(qd) * PART_W'(TPS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= 1'b0;
      end else if (busy_r) begin
        step_r <= 1'b1;
        if (step_r) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Hold the magnitude, collect the quotient a chunk at a time.
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[DIV_W-1];
      mag_r <= dividend[DIV_W-1] ? DIV_W'(-dividend) : DIV_W'(dividend);
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= back[REM_W-1:0];
      quo_r <= {quo_r[DIV_W-CHUNK_W-1:0], qd};
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? -$signed(quo_r) : $signed(quo_r);

endmodule

FILE: hw/rtl/sctp_ctrl.sv
`timescale 1ns / 1ps
module sctp_ctrl
  import sctp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [18:0] {
    S_IDLE   = 19'h00001,
    S_DECODE = 19'h00002,
    S_START  = 19'h00004,
    S_PHASE  = 19'h00008,
    S_MUL_P  = 19'h00010,
    S_LOOK   = 19'h00020,
    S_MUL_V  = 19'h00040,
    S_VSET   = 19'h00080,
    S_ACC    = 19'h00100,
    S_DIV_V  = 19'h00200,
    S_REFPOS = 19'h00400,
    S_ERR    = 19'h00800,
    S_DIV_E  = 19'h01000,
    S_MUL_KP = 19'h02000,
    S_MUL_KI = 19'h04000,
    S_MUL_KD = 19'h08000,
    S_SUM    = 19'h10000,
    S_DIV_C  = 19'h20000,
    S_OUT    = 19'h40000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Sequence the datapath operations for one word.
  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_CAPTURE;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: state_nxt = status.action ? S_START : S_PHASE;
      S_START: begin
        cmd.op    = OP_START;
        state_nxt = S_OUT;
      end
      S_PHASE: begin
        cmd.op = OP_PHASE;
        if (status.phase == PH_RAMP || status.phase == PH_DOWN) state_nxt = S_MUL_P;
        else state_nxt = S_ACC;
      end
      S_MUL_P: begin
        cmd.op    = OP_MUL_P;
        state_nxt = S_LOOK;
      end
      S_LOOK: begin
        cmd.op    = OP_LOOK;
        state_nxt = S_MUL_V;
      end
      S_MUL_V: begin
        cmd.op    = OP_MUL_V;
        state_nxt = S_VSET;
      end
      S_VSET: begin
        cmd.op    = OP_VSET;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.op    = OP_ACC;
        state_nxt = S_DIV_V;
      end
      S_DIV_V: begin
        cmd.op = OP_DIV_V;
        if (status.div_done) state_nxt = S_REFPOS;
      end
      S_REFPOS: begin
        cmd.op    = OP_REFPOS;
        state_nxt = status.active ? S_ERR : S_OUT;
      end
      S_ERR: begin
        cmd.op    = OP_ERR;
        state_nxt = S_DIV_E;
      end
      S_DIV_E: begin
        cmd.op = OP_DIV_E;
        if (status.div_done) state_nxt = S_MUL_KP;
      end
      S_MUL_KP: begin
        cmd.op    = OP_MUL_KP;
        state_nxt = S_MUL_KI;
      end
      S_MUL_KI: begin
        cmd.op    = OP_MUL_KI;
        state_nxt = S_MUL_KD;
      end
      S_MUL_KD: begin
        cmd.op    = OP_MUL_KD;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.op    = OP_SUM;
        state_nxt = S_DIV_C;
      end
      S_DIV_C: begin
        cmd.op = OP_DIV_C;
        if (status.div_done) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.op    = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule

FILE: hw/rtl/sctp_dpath.sv
`timescale 1ns / 1ps
module sctp_dpath
  import sctp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  cmd_t               cmd,
  output status_t            status,
  input  logic               in_action,
  input  logic signed [31:0] in_measured_x,
  input  logic               out_ready,
  output logic               out_valid,
  output logic signed [31:0] out_velocity_command,
  output logic signed [31:0] out_reference_position,
  output logic signed [31:0] out_reference_velocity,
  output logic signed [31:0] out_reference_accel,
  output logic               out_running,
  output logic               out_finished,
  output logic signed [31:0] out_hold_position
);

  localparam logic signed [PROD_W-1:0] S_RANGE = PROD_W'(1) <<< (FRAC_BITS + 4);
  localparam int OFS_W = FRAC_BITS + 5;

  // Move state
  logic [TICK_W-1:0]  tick_r;
  logic               active_r;
  logic signed [31:0] origin_r, integ_r, prevv_r, eint_r, preve_r;
  // Working registers
  logic               action_r, fin_r;
  logic signed [31:0] meas_r, v_r, acc_r, refpos_r, e_r, vcmd_r, hold_r;
  phase_t             phase_r, phase_cur;
  logic signed [21:0] arg_r, arg_nxt;
  logic signed [PROD_W-1:0] prod_r, mul_p, prod_sh;
  logic [15:0]        sig_r;
  logic signed [DIV_W-1:0] dv_r, div_in, div_q, dv_sum;
  logic               div_start, div_done;
  // Output register
  logic               out_valid_r, out_run_r, out_fin_r;
  logic signed [31:0] out_vcmd_r, out_refpos_r, out_refv_r, out_acc_r, out_hold_r;

  logic signed [32:0] mul_a;
  logic signed [33:0] mul_b;
  logic [TICK_W-1:0]  tm;
  logic [OFS_W-1:0]   ofs;
  logic [OFS_W+TBL_AW:0] scaled;
  logic [TBL_AW-1:0]  idx;
  logic signed [31:0] e_nxt, vs;

  // Pick the phase of the current tick.
  always_comb begin
    if (!active_r) phase_cur = PH_OFF;
    else if (tick_r < cfg.ramp) phase_cur = PH_RAMP;
    else if (tick_r < cfg.cend) phase_cur = PH_CRUISE;
    else if (tick_r < cfg.total) phase_cur = PH_DOWN;
    else phase_cur = PH_FINISH;
  end

  // Sigmoid argument in ticks: twice the phase time minus the ramp length.
  always_comb begin
    tm      = (phase_cur == PH_DOWN) ? tick_r - cfg.cend : tick_r;
    arg_nxt = $signed({1'b0, tm, 1'b0}) - $signed({2'b0, cfg.ramp});
  end

  // Shared multiplier operands.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_MUL_P: begin
        mul_a = $signed({2'b0, cfg.slope});
        mul_b = 34'(arg_r);
      end
      OP_MUL_V: begin
        mul_a = $signed({2'b0, cfg.peak});
        mul_b = $signed({18'b0, sig_r});
      end
      OP_MUL_KP: begin
        mul_a = $signed({2'b0, cfg.kp});
        mul_b = 34'(e_r);
      end
      OP_MUL_KI: begin
        mul_a = $signed({2'b0, cfg.ki});
        mul_b = 34'(eint_r);
      end
      OP_MUL_KD: begin
        mul_a = $signed({2'b0, cfg.kd});
        mul_b = 34'(e_r) - 34'(preve_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p   = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign prod_sh = prod_r >>> FRAC_BITS;
  assign dv_sum  = dv_r + prod_sh[DIV_W-1:0];
  assign e_nxt   = sat32(64'(refpos_r) - 64'(meas_r));
  assign vs      = $signed(prod_r[FRAC_BITS+31:FRAC_BITS]);

  // Map the sigmoid argument onto a table entry, clamping at both ends.
  always_comb begin
    ofs    = OFS_W'(prod_r + S_RANGE);
    scaled = (OFS_W + TBL_AW + 1)'(ofs) * (OFS_W + TBL_AW + 1)'(TBL_DEPTH);
    if (prod_r < -S_RANGE) idx = '0;
    else if (prod_r >= S_RANGE) idx = TBL_AW'(TBL_DEPTH - 1);
    else idx = TBL_AW'(scaled >> OFS_W);
  end

  // Divider feed: reference velocity, error, or PID sum.
  always_comb begin
    div_start = 1'b0;
    div_in    = '0;
    case (cmd.op)
      OP_ACC: begin
        div_start = 1'b1;
        div_in    = DIV_W'(v_r);
      end
      OP_ERR: begin
        div_start = 1'b1;
        div_in    = DIV_W'(e_nxt);
      end
      OP_SUM: begin
        div_start = 1'b1;
        div_in    = dv_sum;
      end
      default: begin
        div_start = 1'b0;
        div_in    = '0;
      end
    endcase
  end

  sctp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_in),
    .done     (div_done),
    .quotient (div_q)
  );

  // Move state: counter, active flag, origin and integrators.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r   <= '0;
      active_r <= 1'b0;
      origin_r <= '0;
      integ_r  <= '0;
      prevv_r  <= '0;
      eint_r   <= '0;
      preve_r  <= '0;
    end else begin
      case (cmd.op)
        OP_START: begin
          origin_r <= meas_r;
          tick_r   <= '0;
          active_r <= 1'b1;
          integ_r  <= '0;
          prevv_r  <= '0;
          eint_r   <= '0;
          preve_r  <= '0;
        end
        OP_PHASE: begin
          if (phase_cur == PH_FINISH) active_r <= 1'b0;
          if (active_r && tick_r != '1) tick_r <= tick_r + 1'b1;
        end
        OP_ACC: prevv_r <= v_r;
        OP_DIV_V: if (div_done) integ_r <= sat32(64'(integ_r) + 64'(div_q));
        OP_DIV_E: if (div_done) eint_r <= sat32(64'(eint_r) + 64'(div_q));
        OP_SUM: preve_r <= e_r;
        default: ;
      endcase
    end
  end

  // Working registers for the word in flight.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CAPTURE: begin
        action_r <= in_action;
        meas_r   <= in_measured_x;
      end
      OP_START: begin
        refpos_r <= meas_r;
        vcmd_r   <= '0;
        v_r      <= '0;
        acc_r    <= '0;
        hold_r   <= '0;
        fin_r    <= 1'b0;
      end
      OP_PHASE: begin
        phase_r <= phase_cur;
        arg_r   <= arg_nxt;
        vcmd_r  <= '0;
        hold_r  <= '0;
        fin_r   <= 1'b0;
        case (phase_cur)
          PH_CRUISE: v_r <= $signed({1'b0, cfg.peak});
          PH_FINISH: begin
            v_r    <= '0;
            fin_r  <= 1'b1;
            hold_r <= meas_r;
          end
          PH_OFF: v_r <= '0;
          default: ;
        endcase
      end
      OP_MUL_P, OP_MUL_V, OP_MUL_KP: prod_r <= mul_p;
      OP_MUL_KI: begin
        prod_r <= mul_p;
        dv_r   <= prod_sh[DIV_W-1:0];
      end
      OP_MUL_KD: begin
        prod_r <= mul_p;
        dv_r   <= dv_sum;
      end
      OP_LOOK: sig_r <= SIG_ROM[idx];
      OP_VSET: v_r <= (phase_r == PH_RAMP) ? vs : $signed({1'b0, cfg.peak}) - vs;
      OP_ACC: acc_r <= sat32((64'(v_r) - 64'(prevv_r)) * 64'(TPS));
      OP_REFPOS: refpos_r <= sat32(64'(origin_r) + 64'(integ_r));
      OP_ERR: e_r <= e_nxt;
      OP_DIV_C: if (div_done) vcmd_r <= sat32(64'(div_q));
      default: ;
    endcase
  end

  // Output register: hold a finished word until taken.
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.op == OP_OUT) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT) begin
      out_vcmd_r   <= vcmd_r;
      out_refpos_r <= refpos_r;
      out_refv_r   <= v_r;
      out_acc_r    <= acc_r;
      out_run_r    <= active_r;
      out_fin_r    <= fin_r;
      out_hold_r   <= hold_r;
    end
  end

  assign status.action   = action_r;
  assign status.phase    = phase_cur;
  assign status.active   = active_r;
  assign status.div_done = div_done;
  assign status.out_free = !out_valid_r || out_ready;

  assign out_valid              = out_valid_r;
  assign out_velocity_command   = out_vcmd_r;
  assign out_reference_position = out_refpos_r;
  assign out_reference_velocity = out_refv_r;
  assign out_reference_accel    = out_acc_r;
  assign out_running            = out_run_r;
  assign out_finished           = out_fin_r;
  assign out_hold_position      = out_hold_r;

endmodule

FILE: hw/rtl/scurve_trajectory_pid_axis.sv
`timescale 1ns / 1ps
// One-axis S-curve velocity generator with a PID position loop, Q16.16
// throughout. Send a word with action 1 to start a move at the measured
// position, then one word with action 0 per control tick; each word gives
// one result word, and the next word is taken once that result sits in the
// output register. A result waits in the output state while the previous
// result still waits for out_ready. A tick's work goes to the shared
// divide-by-ticks-per-second unit, a reciprocal multiply over two 25-bit
// chunks that runs three times per running tick (reference velocity,
// error, PID sum), and to the shared multiplier that forms the sigmoid
// argument, the scaled table value and the three PID terms one per cycle.
// Registers sit on an APB port at byte addresses 4*i and should be written
// only while the block is idle.
`include "scurve_trajectory_pid_axis_defines.svh"
module scurve_trajectory_pid_axis
  import sctp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_action,
  input  logic signed [31:0] in_measured_x,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_velocity_command,
  output logic signed [31:0] out_reference_position,
  output logic signed [31:0] out_reference_velocity,
  output logic signed [31:0] out_reference_accel,
  output logic               out_running,
  output logic               out_finished,
  output logic signed [31:0] out_hold_position
);

  cfg_t     cfg_r;
  reg_idx_t reg_idx;
  cmd_t     cmd;
  status_t  status;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[4:2]);

  // Register file writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.peak  <= 31'd249661;
      cfg_r.ramp  <= 20'd900;
      cfg_r.cend  <= 20'd2100;
      cfg_r.total <= 20'd3000;
      cfg_r.slope <= 31'd728;
      cfg_r.kp    <= 31'd32768000;
      cfg_r.ki    <= 31'd6553600;
      cfg_r.kd    <= 31'd0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_PEAK:  cfg_r.peak  <= pwdata[30:0];
        REG_RAMP:  cfg_r.ramp  <= pwdata[TICK_W-1:0];
        REG_CEND:  cfg_r.cend  <= pwdata[TICK_W-1:0];
        REG_TOTAL: cfg_r.total <= pwdata[TICK_W-1:0];
        REG_SLOPE: cfg_r.slope <= pwdata[30:0];
        REG_KP:    cfg_r.kp    <= pwdata[30:0];
        REG_KI:    cfg_r.ki    <= pwdata[30:0];
        REG_KD:    cfg_r.kd    <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (reg_idx)
      REG_PEAK:  prdata = {1'b0, cfg_r.peak};
      REG_RAMP:  prdata = {12'b0, cfg_r.ramp};
      REG_CEND:  prdata = {12'b0, cfg_r.cend};
      REG_TOTAL: prdata = {12'b0, cfg_r.total};
      REG_SLOPE: prdata = {1'b0, cfg_r.slope};
      REG_KP:    prdata = {1'b0, cfg_r.kp};
      REG_KI:    prdata = {1'b0, cfg_r.ki};
      REG_KD:    prdata = {1'b0, cfg_r.kd};
      default:   prdata = '0;
    endcase
  end

  sctp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  sctp_dpath u_dpath (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg                    (cfg_r),
    .cmd                    (cmd),
    .status                 (status),
    .in_action              (in_action),
    .in_measured_x          (in_measured_x),
    .out_ready              (out_ready),
    .out_valid              (out_valid),
    .out_velocity_command   (out_velocity_command),
    .out_reference_position (out_reference_position),
    .out_reference_velocity (out_reference_velocity),
    .out_reference_accel    (out_reference_accel),
    .out_running            (out_running),
    .out_finished           (out_finished),
    .out_hold_position      (out_hold_position)
  );

  `SCTP_ASSERT_NXT(a_one_at_a_time, in_valid && in_ready, !in_ready)
  `SCTP_ASSERT_IMP(a_fin_stops, out_valid && out_finished, !out_running)
  `SCTP_ASSERT_IMP(a_idle_no_cmd, out_valid && !out_running, out_velocity_command == 32'sd0)
  `SCTP_ASSERT_IMP(a_fin_no_vel, out_valid && out_finished, out_reference_velocity == 32'sd0)

endmodule

FILE: tb/scurve_trajectory_pid_axis_tb.sv
`timescale 1ns / 1ps
module scurve_trajectory_pid_axis_tb;
  import sctp_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 250;

  typedef struct {
    int   vcmd;
    int   refpos;
    int   refvel;
    int   refacc;
    bit   running;
    bit   finished;
    int   hold;
  } axis_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_action = 1'b0;
  logic signed [31:0] in_measured_x = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_velocity_command, out_reference_position;
  logic signed [31:0] out_reference_velocity, out_reference_accel, out_hold_position;
  logic out_running, out_finished;

  scurve_trajectory_pid_axis dut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_measured_x(in_measured_x),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_velocity_command(out_velocity_command),
    .out_reference_position(out_reference_position),
    .out_reference_velocity(out_reference_velocity),
    .out_reference_accel(out_reference_accel),
    .out_running(out_running), .out_finished(out_finished),
    .out_hold_position(out_hold_position)
  );

  always #2 clk = ~clk;

  // Axis model state and register copies
  logic [15:0] logistic_rom [TBL_DEPTH];
  longint cf_peak, cf_ramp, cf_cend, cf_total, cf_slope, cf_kp, cf_ki, cf_kd;
  longint ax_tick;
  bit ax_active;
  int ax_origin, ax_integ, ax_prev_v, ax_err_int, ax_prev_err;

  axis_word_t pending_words [$];
  int fail_count = 0;
  int items_sent = 0;
  bit no_gaps = 1'b0;
  int idle_cycles = 0;

  function automatic int clip32(longint x);
    if (x > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return int'(x);
  endfunction

  // Fill the logistic ROM the way the block does: series e^-x in Q32.
  task automatic fill_logistic();
    longint num, sum;
    logic [63:0] mag, a, whole, frac, term, r, den, s;
    for (int i = 0; i < TBL_DEPTH; i++) begin
      num = 2 * i + 1 - TBL_DEPTH;
      mag = (num < 0) ? -num : num;
      a = (mag << 35) / TBL_DEPTH;
      whole = a >> 32;
      frac = a & 64'hFFFF_FFFF;
      term = 64'd1 << 32;
      sum = 64'sd1 << 32;
      for (int k = 1; k <= 14; k++) begin
        term = ((term * frac) >> 32) / k;
        if (k % 2) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      r = (sum > 0) ? sum : 0;
      for (longint k = 0; k < whole; k++) r = (r * 64'd1580030169) >> 32;
      den = (64'd1 << 32) + r;
      s = (num >= 0) ? ((64'd1 << 48) / den) : ((r << 16) / den);
      logistic_rom[i] = (s > 65535) ? 16'hFFFF : s[15:0];
    end
  endtask

  function automatic longint logistic_at(longint p);
    longint span, idx;
    span = longint'(16) << FRAC_BITS;
    if (p < -span) idx = 0;
    else if (p >= span) idx = TBL_DEPTH - 1;
    else idx = (p + span) * TBL_DEPTH / (2 * span);
    if (idx >= TBL_DEPTH) idx = TBL_DEPTH - 1;
    return longint'(logistic_rom[idx]);
  endfunction

  // Advance the axis model by one word and return the expected result.
  function automatic axis_word_t advance_axis(bit action, int meas);
    axis_word_t w;
    longint v, dv;
    int e;
    w = '{default: 0};
    if (action) begin
      ax_origin = meas; ax_tick = 0; ax_active = 1;
      ax_integ = 0; ax_prev_v = 0; ax_err_int = 0; ax_prev_err = 0;
      w.refpos = ax_origin;
    end else begin
      v = 0;
      if (ax_active) begin
        if (ax_tick < cf_ramp)
          v = (cf_peak * logistic_at(cf_slope * (2 * ax_tick - cf_ramp))) >>> 16;
        else if (ax_tick < cf_cend)
          v = cf_peak;
        else if (ax_tick < cf_total)
          v = cf_peak - ((cf_peak *
              logistic_at(cf_slope * (2 * (ax_tick - cf_cend) - cf_ramp))) >>> 16);
        else begin
          ax_active = 0; w.finished = 1; w.hold = meas;
        end
        if (ax_tick < 20'hFFFFF) ax_tick++;
      end
      w.refvel = int'(v);
      w.refacc = clip32((v - ax_prev_v) * TPS);
      ax_prev_v = int'(v);
      ax_integ = clip32(longint'(ax_integ) + v / TPS);
      w.refpos = clip32(longint'(ax_origin) + ax_integ);
      if (ax_active) begin
        e = clip32(longint'(w.refpos) - meas);
        ax_err_int = clip32(longint'(ax_err_int) + longint'(e) / TPS);
        dv = ((cf_kp * e) >>> FRAC_BITS) + ((cf_ki * ax_err_int) >>> FRAC_BITS)
           + ((cf_kd * (longint'(e) - ax_prev_err)) >>> FRAC_BITS);
        ax_prev_err = e;
        w.vcmd = clip32(dv / TPS);
      end
    end
    w.running = ax_active;
    return w;
  endfunction

  // Send one input word after a random gap (none while no_gaps is set); valid stays up until accepted.
  task automatic send_word(bit action, int meas);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pending_words.push_back(advance_axis(action, meas));
    in_action <= action;
    in_measured_x <= meas;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Drop valid and wait until every expected word has come back.
  task automatic drain();
    if (in_valid) in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, longint value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 5'(idx) << 2; pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_PEAK:  cf_peak = value & 32'h7FFF_FFFF;
      REG_RAMP:  cf_ramp = value & 20'hFFFFF;
      REG_CEND:  cf_cend = value & 20'hFFFFF;
      REG_TOTAL: cf_total = value & 20'hFFFFF;
      REG_SLOPE: cf_slope = value & 32'h7FFF_FFFF;
      REG_KP:    cf_kp = value & 32'h7FFF_FFFF;
      REG_KI:    cf_ki = value & 32'h7FFF_FFFF;
      default:   cf_kd = value & 32'h7FFF_FFFF;
    endcase
  endtask

  task automatic set_profile(longint peak, longint ramp, longint cend, longint total,
                             longint slope);
    write_reg(REG_PEAK, peak);
    write_reg(REG_RAMP, ramp);
    write_reg(REG_CEND, cend);
    write_reg(REG_TOTAL, total);
    write_reg(REG_SLOPE, slope);
  endtask

  task automatic set_gains(longint kp, longint ki, longint kd);
    write_reg(REG_KP, kp);
    write_reg(REG_KI, ki);
    write_reg(REG_KD, kd);
  endtask

  function automatic int near_reference();
    return clip32(longint'(ax_origin) + ax_integ + $signed($urandom_range(0, 8191)) - 4096);
  endfunction

  // Idle ticks straight out of reset, then a short move on the reset profile.
  task automatic test_reset_defaults();
    send_word(0, 32'sh7FFFFFFF);
    send_word(0, 32'sh80000000);
    send_word(1, 32'sh0001_0000);
    repeat (4) send_word(0, near_reference());
    drain();
  endtask

  // Saturation of every path, clamped sigmoid, full move with finish.
  task automatic test_extremes();
    set_profile(32'h7FFF_FFFF, 2, 3, 5, 32'h7FFF_FFFF);
    set_gains(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_word(1, 32'sh7FFF0000);
    send_word(0, 32'sh80000000);
    send_word(0, 32'sh7FFFFFFF);
    send_word(0, 32'sh80000000);
    send_word(0, 0);
    send_word(0, -1);
    send_word(0, 32'sh1234_5678);
    send_word(0, 0);
    drain();
  endtask

  // Ramp length zero and phase bounds out of order.
  task automatic test_odd_phases();
    set_profile(200000, 0, 2, 4, 0);
    set_gains(65536, 0, 0);
    send_word(1, -65536);
    repeat (5) send_word(0, near_reference());
    drain();
    set_profile(300000, 4, 2, 1, 163840);
    send_word(1, 0);
    repeat (4) send_word(0, near_reference());
    drain();
  endtask

  // Random profiles and gains, mostly full moves with tracking measurements.
  task automatic test_random_moves();
    int ticks;
    longint ramp, cend;
    while (items_sent < 780) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      ramp = $urandom_range(1, 12);
      cend = ramp + $urandom_range(0, 8);
      if ($urandom_range(0, 7) == 0) cend = $urandom_range(1, 4);
      set_profile(($urandom_range(0, 5) == 0) ? 32'h7FFF_FFFF : $urandom_range(0, 32'h7FFF_FFFF)
                    >> $urandom_range(0, 12),
                  ramp, cend, cend + $urandom_range(0, 8),
                  ($urandom_range(0, 2) == 0) ? $urandom_range(0, 32'h7FFF_FFFF)
                                                : (655360 / ramp));
      set_gains($urandom_range(0, 32'h7FFF_FFFF) >> $urandom_range(0, 20),
                $urandom_range(0, 32'h7FFF_FFFF) >> $urandom_range(0, 20),
                $urandom_range(0, 32'h7FFF_FFFF) >> $urandom_range(0, 20));
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 5) == 0) send_word(0, $urandom());
        send_word(1, $urandom() >> $urandom_range(0, 31) ^ ($urandom_range(0, 1) << 31));
        ticks = cf_total + $urandom_range(0, 3);
        if ($urandom_range(0, 5) == 0) ticks = $urandom_range(0, cf_total);
        repeat (ticks) begin
          if ($urandom_range(0, 9) == 0) send_word(0, $urandom());
          else send_word(0, near_reference());
        end
      end
      drain();
    end
    no_gaps = 1'b0;
  endtask

  // Result side stalls: a random wait before each word, or none in bursts.
  int stall_left = 0;
  always @(posedge clk) begin
    int stall;
    logic next_ready;
    stall = stall_left;
    if (out_valid && out_ready) stall = no_gaps ? 0 : $urandom_range(0, 12);
    else if (stall > 0) stall--;
    next_ready = (stall == 0);
    stall_left <= stall;
    out_ready <= next_ready;
  end

  // Compare each accepted word with the oldest expectation.
  always @(posedge clk) begin
    axis_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        $error("result word with no expectation");
        fail_count++;
      end else begin
        want = pending_words.pop_front();
        if (out_velocity_command !== want.vcmd) begin
          $error("velocity_command exp %0d got %0d", want.vcmd, out_velocity_command);
          fail_count++;
        end
        if (out_reference_position !== want.refpos) begin
          $error("reference_position exp %0d got %0d", want.refpos, out_reference_position);
          fail_count++;
        end
        if (out_reference_velocity !== want.refvel) begin
          $error("reference_velocity exp %0d got %0d", want.refvel, out_reference_velocity);
          fail_count++;
        end
        if (out_reference_accel !== want.refacc) begin
          $error("reference_accel exp %0d got %0d", want.refacc, out_reference_accel);
          fail_count++;
        end
        if (out_running !== want.running) begin
          $error("running exp %0d got %0d", want.running, out_running);
          fail_count++;
        end
        if (out_finished !== want.finished) begin
          $error("finished exp %0d got %0d", want.finished, out_finished);
          fail_count++;
        end
        if (out_hold_position !== want.hold) begin
          $error("hold_position exp %0d got %0d", want.hold, out_hold_position);
          fail_count++;
        end
      end
    end
  end

  // Stop a hung run: count cycles with no word and no register access.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    fill_logistic();
    cf_peak = 249661; cf_ramp = 900; cf_cend = 2100; cf_total = 3000;
    cf_slope = 728; cf_kp = 32768000; cf_ki = 6553600; cf_kd = 0;
    ax_tick = 0; ax_active = 0; ax_origin = 0; ax_integ = 0;
    ax_prev_v = 0; ax_err_int = 0; ax_prev_err = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_extremes();
    test_odd_phases();
    test_random_moves();
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_words.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      if (pending_words.size() != 0) $error("%0d expected words never came", pending_words.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
